// ===== rtl/core/pmbr_pkg.sv =====
`timescale 1ns / 1ps

package pmbr_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int BS_W = 8;
	localparam int IW_W = 12;
	localparam int IH_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int BCI_W = 11;

	localparam logic [BS_W-1:0] BS_RESET = 8'd8;
	localparam logic [IW_W-1:0] IW_RESET = 12'd640;
	localparam logic [IH_W-1:0] IH_RESET = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE = 2'd0,
		CFG_IMAGE_WIDTH = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	// Per-item control from the position counters to the store pipeline.
	typedef struct packed {
		logic corner_wr;
		logic corner_rd;
		logic in_store;
		logic frame_last;
	} ctrl_t;

endpackage

// ===== rtl/core/pmbr_line_store.sv =====
`timescale 1ns / 1ps

module pmbr_line_store #(
	parameter int DEPTH = pmbr_pkg::DEF_MAX_WIDTH,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [AW-1:0]               addr,
	input  logic [pmbr_pkg::PIX_W-1:0]  wdata,
	output logic [pmbr_pkg::PIX_W-1:0]  rdata
);

	logic [pmbr_pkg::PIX_W-1:0] mem [DEPTH];
	logic [pmbr_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pmbr_ctrl.sv =====
`timescale 1ns / 1ps

module pmbr_ctrl #(
	parameter int MAX_WIDTH = pmbr_pkg::DEF_MAX_WIDTH,
	parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pmbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmbr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              step,
	output pmbr_pkg::ctrl_t                   ctl,
	output logic [AW-1:0]                     addr
);

	logic [pmbr_pkg::BS_W-1:0] block_size_q;
	logic [pmbr_pkg::IW_W-1:0] image_width_q;
	logic [pmbr_pkg::IH_W-1:0] image_height_q;

	logic [pmbr_pkg::COL_W-1:0] col_q;
	logic [pmbr_pkg::ROW_W-1:0] row_q;
	logic [pmbr_pkg::BS_W-1:0]  cib_q;
	logic [pmbr_pkg::BS_W-1:0]  rib_q;
	logic [pmbr_pkg::BCI_W-1:0] bci_q;

	logic [pmbr_pkg::BS_W-1:0] bs_eff;
	logic [pmbr_pkg::IW_W-1:0] w_nz;
	logic [pmbr_pkg::IW_W-1:0] w_eff;
	logic [pmbr_pkg::IH_W-1:0] h_nz;
	logic [pmbr_pkg::IH_W-1:0] h_eff;
	logic row_last;
	logic frame_last;
	logic cib_last;
	logic rib_last;
	logic [AW+pmbr_pkg::BCI_W-1:0] addr_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= pmbr_pkg::BS_RESET;
			image_width_q <= pmbr_pkg::IW_RESET;
			image_height_q <= pmbr_pkg::IH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmbr_pkg::CFG_BLOCK_SIZE: begin
					block_size_q <= cfg_data[pmbr_pkg::BS_W-1:0];
				end
				pmbr_pkg::CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[pmbr_pkg::IW_W-1:0];
				end
				pmbr_pkg::CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[pmbr_pkg::IH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		bs_eff = (block_size_q == '0) ? pmbr_pkg::BS_W'(1) : block_size_q;
		w_nz = (image_width_q == '0) ? pmbr_pkg::IW_W'(1) : image_width_q;
		w_eff = ({2'b00, w_nz} > 14'(MAX_WIDTH)) ? pmbr_pkg::IW_W'(MAX_WIDTH) : w_nz;
		h_nz = (image_height_q == '0) ? pmbr_pkg::IH_W'(1) : image_height_q;
		h_eff = (h_nz > pmbr_pkg::IH_W'(pmbr_pkg::HEIGHT_LIMIT))
			? pmbr_pkg::IH_W'(pmbr_pkg::HEIGHT_LIMIT) : h_nz;
		row_last = ({1'b0, col_q} + 13'd1) >= {1'b0, w_eff};
		frame_last = row_last && (({1'b0, row_q} + 13'd1) >= h_eff);
		cib_last = ({1'b0, cib_q} + 9'd1) >= {1'b0, bs_eff};
		rib_last = ({1'b0, rib_q} + 9'd1) >= {1'b0, bs_eff};
		addr_ext = {{AW{1'b0}}, bci_q};
		addr = addr_ext[AW-1:0];
		ctl.corner_wr = (cib_q == '0) && (rib_q == '0);
		ctl.corner_rd = (cib_q == '0) && (rib_q != '0);
		ctl.in_store = {3'b000, bci_q} < 14'(MAX_WIDTH);
		ctl.frame_last = frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
			bci_q <= '0;
		end else if (step) begin
			if (row_last) begin
				col_q <= '0;
				cib_q <= '0;
				bci_q <= '0;
				if (frame_last) begin
					row_q <= '0;
					rib_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					rib_q <= rib_last ? '0 : rib_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (cib_last) begin
					cib_q <= '0;
					bci_q <= bci_q + 1'b1;
				end else begin
					cib_q <= cib_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/pixel_mosaic_block_replicate_core.sv =====
`timescale 1ns / 1ps

// Mosaic filter for a raster stream of 24-bit pixels: every output item repeats the
// top-left pixel of its block. It takes one item per clock while in_stall is low; each
// accepted item passes the line store read and input register, then the output register.
// The store needs no clearing after reset, as its entries are always written on the
// first row of a block row before being read.
module pixel_mosaic_block_replicate_core #(
	parameter int MAX_WIDTH = pmbr_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pmbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pmbr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pmbr_pkg::CH_W-1:0]         blue_in,
	input  logic [pmbr_pkg::CH_W-1:0]         green_in,
	input  logic [pmbr_pkg::CH_W-1:0]         red_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pmbr_pkg::CH_W-1:0]         blue_out,
	output logic [pmbr_pkg::CH_W-1:0]         green_out,
	output logic [pmbr_pkg::CH_W-1:0]         red_out,
	output logic                              frame_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	pmbr_pkg::ctrl_t ctl;
	logic [AW-1:0] addr;
	logic [pmbr_pkg::PIX_W-1:0] pix;
	logic [pmbr_pkg::PIX_W-1:0] rdata;
	logic in_accept;
	logic advance;

	logic v_s1;
	logic [pmbr_pkg::PIX_W-1:0] pix_s1;
	pmbr_pkg::ctrl_t ctl_s1;

	logic [pmbr_pkg::PIX_W-1:0] held_q;
	logic [pmbr_pkg::PIX_W-1:0] corner;
	logic out_valid_q;
	logic [pmbr_pkg::PIX_W-1:0] out_pix_q;
	logic frame_end_q;

	assign cfg_ready = 1'b1;
	assign pix = {red_in, green_in, blue_in};
	assign advance = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	pmbr_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(in_accept),
		.ctl(ctl),
		.addr(addr)
	);

	pmbr_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(in_accept && ctl.corner_wr && ctl.in_store),
		.re(in_accept && ctl.corner_rd && ctl.in_store),
		.addr(addr),
		.wdata(pix),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1 <= pix;
			ctl_s1 <= ctl;
		end
	end

	always_comb begin
		if (ctl_s1.corner_wr) begin
			corner = pix_s1;
		end else if (ctl_s1.corner_rd) begin
			corner = ctl_s1.in_store ? rdata : '0;
		end else begin
			corner = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				held_q <= corner;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pix_q <= corner;
			frame_end_q <= ctl_s1.frame_last;
		end
	end

	assign out_valid = out_valid_q;
	assign blue_out = out_pix_q[pmbr_pkg::CH_W-1:0];
	assign green_out = out_pix_q[2*pmbr_pkg::CH_W-1:pmbr_pkg::CH_W];
	assign red_out = out_pix_q[3*pmbr_pkg::CH_W-1:2*pmbr_pkg::CH_W];
	assign frame_end = frame_end_q;

endmodule
